>>> rtl/core/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared types and constants of the path glob matcher: item layouts, item
// kinds, token classes and the special pattern characters.
// ----------------------------------------------------------------------------
package pgm_pkg;

    // default pattern capacity in bytes
    localparam int MAX_PATTERN_DEF = 64;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // item kinds
    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_APPEND  = 2'd1;
    localparam logic [1:0] KIND_SUBJECT = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // token classes per pattern position
    localparam logic [2:0] TC_LITERAL  = 3'd0;
    localparam logic [2:0] TC_QUESTION = 3'd1;
    localparam logic [2:0] TC_STAR     = 3'd2;
    localparam logic [2:0] TC_DSTAR_A  = 3'd3;
    localparam logic [2:0] TC_DSTAR_B  = 3'd4;

    // special pattern characters
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_SLASH    = 8'h2F;

    // input item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_item;

    // classified item held in the queue
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       is_star;
        logic       is_question;
        logic       is_slash;
    } t_cmd;

endpackage

>>> rtl/core/pgm_front.sv
// ----------------------------------------------------------------------------
// pgm_front
// Accepts input items, decodes the special characters of the byte and
// holds the classified items in a short queue for the matching engine.
// ----------------------------------------------------------------------------
module pgm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pgm_pkg::t_in_item i_item,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output pgm_pkg::t_cmd   o_cmd
);
    import pgm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;
    t_cmd            w_cmd;

    // classify the incoming byte
    always_comb begin
        w_cmd.kind        = i_item.kind;
        w_cmd.byte_value  = i_item.byte_value;
        w_cmd.is_star     = (i_item.byte_value == CH_STAR);
        w_cmd.is_question = (i_item.byte_value == CH_QUESTION);
        w_cmd.is_slash    = (i_item.byte_value == CH_SLASH);
    end

    assign o_ready     = (r_count != CW'(QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a push alone grows the count by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");

    // a pop alone shrinks the count by one
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !w_push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not shrink on pop");

endmodule

>>> rtl/core/pgm_back.sv
// ----------------------------------------------------------------------------
// pgm_back
// Matching engine: one cell per pattern position holds the byte and its
// token class, a bit-parallel NFA advances all positions on each subject
// byte, and an output register holds the result of an end-of-subject item.
// ----------------------------------------------------------------------------
module pgm_back #(
    parameter int MAX_PATTERN = pgm_pkg::MAX_PATTERN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  pgm_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output pgm_pkg::t_out_item o_item
);
    import pgm_pkg::*;

    localparam int P  = MAX_PATTERN;
    localparam int LW = $clog2(P + 1);
    localparam logic [P:0] RAW_START = (P + 1)'(1);

    logic [7:0]    r_store [P];
    logic [2:0]    r_class [P];
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          r_last_star;
    logic [P:0]    r_raw;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [P:0]    w_pass;
    logic [P:0]    w_gen;
    logic [P:0]    w_sum;
    logic [P:0]    w_act;
    logic [P-1:0]  w_adv;
    logic [P-1:0]  w_stay;
    logic [P:0]    w_next;
    logic          w_pop;
    logic          w_full;
    logic          w_wr_en;
    logic          w_pair;

    // an end item waits for room in the output register
    assign o_cmd_ready = (i_cmd.kind != KIND_END) || !r_out_valid || i_ready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_full      = (r_len == LW'(P));
    assign w_wr_en     = w_pop && (i_cmd.kind == KIND_APPEND) && !w_full;
    assign w_pair      = i_cmd.is_star && r_last_star;

    // star positions inside the pattern let the active set skip forward
    generate
        for (genvar p = 0; p < P; p++) begin : g_pass
            assign w_pass[p] = (LW'(p) < r_len) && ((r_class[p] == TC_STAR)
                || (r_class[p] == TC_DSTAR_A) || (r_class[p] == TC_DSTAR_B));
        end
    endgenerate
    assign w_pass[P] = 1'b0;

    // closure over star skips as a carry chain: carries mark reached positions
    assign w_gen = r_raw & w_pass;
    assign w_sum = w_gen + w_pass;
    assign w_act = r_raw | (w_sum ^ w_gen ^ w_pass);

    // per-position step on a subject byte
    generate
        for (genvar p = 0; p < P; p++) begin : g_step
            logic w_hit;
            assign w_hit = w_act[p] && (LW'(p) < r_len);
            assign w_adv[p] = w_hit && (
                ((r_class[p] == TC_LITERAL) && (r_store[p] == i_cmd.byte_value))
                || ((r_class[p] == TC_QUESTION) && !i_cmd.is_slash));
            assign w_stay[p] = w_hit && (
                ((r_class[p] == TC_STAR) && !i_cmd.is_slash)
                || (r_class[p] == TC_DSTAR_A));
        end
    endgenerate
    assign w_next = {w_adv, 1'b0} | {1'b0, w_stay};

    // pattern cells
    generate
        for (genvar p = 0; p < P; p++) begin : g_cell
            always_ff @(posedge i_clk) begin
                if (w_wr_en && (r_len == LW'(p))) begin
                    r_store[p] <= i_cmd.byte_value;
                    if (i_cmd.is_star) begin
                        r_class[p] <= w_pair ? TC_DSTAR_B : TC_STAR;
                    end else if (i_cmd.is_question) begin
                        r_class[p] <= TC_QUESTION;
                    end else begin
                        r_class[p] <= TC_LITERAL;
                    end
                end else if (w_wr_en && w_pair && (r_len == LW'(p + 1))) begin
                    r_class[p] <= TC_DSTAR_A;
                end
            end
        end
    endgenerate

    // pattern length, overflow and active set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_last_star <= 1'b0;
            r_raw       <= RAW_START;
        end else if (w_pop) begin
            case (i_cmd.kind)
                KIND_CLEAR: begin
                    r_len       <= '0;
                    r_ovf       <= 1'b0;
                    r_last_star <= 1'b0;
                    r_raw       <= RAW_START;
                end
                KIND_APPEND: begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_len       <= r_len + 1'b1;
                        r_last_star <= i_cmd.is_star && !r_last_star;
                    end
                    r_raw <= RAW_START;
                end
                KIND_SUBJECT: begin
                    r_raw <= w_next;
                end
                KIND_END: begin
                    r_raw <= RAW_START;
                end
                default: begin
                    r_raw <= r_raw;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && (i_cmd.kind == KIND_END)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && (i_cmd.kind == KIND_END)) begin
            r_out.matched          <= w_act[r_len] && !r_ovf;
            r_out.pattern_overflow <= r_ovf;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // pattern length stays within capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(P))
        else $error("pattern length beyond capacity");

    // a clear empties the pattern and drops the overflow
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && (i_cmd.kind == KIND_CLEAR) |=> (r_len == '0) && !r_ovf
            && (r_raw == RAW_START))
        else $error("clear did not rearm the matcher");

    // an overflowed pattern never reports a match
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_item.matched && o_item.pattern_overflow))
        else $error("match reported with overflow");

    // an append at capacity leaves the length alone and flags overflow
    a_ovf_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && (i_cmd.kind == KIND_APPEND) && w_full |=> r_ovf && (r_len == LW'(P)))
        else $error("overflow not flagged on full append");

endmodule

>>> rtl/core/path_glob_matcher.sv
// ----------------------------------------------------------------------------
// path_glob_matcher
// Path glob matcher with '?', '*' and '**' run as a bit-parallel NFA.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle of any kind, pattern bytes and
// subject bytes alike, as long as the output side does not hold back a
// result. An end-of-subject item passes through the queue, and the engine
// then writes its result into the output register.
// Each subject byte updates every pattern position at once: one cell per
// position compares the byte, and the star-skip closure of the active set is
// a single carry chain of MAX_PATTERN+1 bits, which sets the clock period.
// A two-entry queue separates the input from the engine, so input and
// output stall independently; the input stalls only while the output side
// holds back a result and the queue has filled. Patterns longer than
// MAX_PATTERN bytes are truncated, flagged, and never report a match.
// ----------------------------------------------------------------------------
module path_glob_matcher #(
    parameter int MAX_PATTERN = pgm_pkg::MAX_PATTERN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pgm_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output pgm_pkg::t_out_item o_item
);
    import pgm_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    // input side and queue
    pgm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // matching engine and result register
    pgm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

>>> verif/path_glob_matcher_tb.sv
// ----------------------------------------------------------------------------
// path_glob_matcher_tb
// Self-checking bench for the path glob matcher. Items go in through a
// valid/ready sender with random gaps. Results come out through a receiver
// with random stalls. A bit-parallel NFA model in the bench predicts each
// end-of-subject verdict. Stimulus covers directed corners, pattern overflow
// and random pattern/subject sequences built to match or nearly match.
// ----------------------------------------------------------------------------
module path_glob_matcher_tb;
    import pgm_pkg::*;

    localparam int MAXP = MAX_PATTERN_DEF;
    localparam logic [MAXP:0] START_POS = (MAXP + 1)'(1);

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    // glob model state
    logic [7:0]    glob_byte [MAXP];
    logic [2:0]    glob_cls [MAXP];
    int            glob_len = 0;
    logic [MAXP:0] live_pos = START_POS;
    logic          glob_ovf = 1'b0;

    t_out_item  pending_verdicts [$];
    logic [7:0] loaded_text [$];
    int         sent_items = 0;
    int         errors = 0;
    int         tx_gap_pct = 0;
    int         rx_stall_pct = 0;
    int         rx_hold = 0;
    t_out_item  want;

    path_glob_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #20_000_000;
        $display("** path_glob_matcher: FAILED **");
        $finish;
    end

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 7) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // star skips, in ascending order so that skips chain
    function automatic logic [MAXP:0] skip_stars(input logic [MAXP:0] set);
        logic [MAXP:0] s;
        s = set;
        for (int p = 0; p < glob_len; p++) begin
            if (s[p]) begin
                if (glob_cls[p] == TC_STAR) s[p+1] = 1'b1;
                else if (glob_cls[p] == TC_DSTAR_A && p + 2 <= glob_len) s[p+2] = 1'b1;
            end
        end
        return s;
    endfunction

    // every active position takes one subject byte
    function automatic logic [MAXP:0] advance_on(input logic [7:0] c);
        logic [MAXP:0] nxt;
        nxt = '0;
        for (int p = 0; p < glob_len; p++) begin
            if (live_pos[p]) begin
                case (glob_cls[p])
                    TC_LITERAL:  if (glob_byte[p] == c) nxt[p+1] = 1'b1;
                    TC_QUESTION: if (c != CH_SLASH) nxt[p+1] = 1'b1;
                    TC_STAR:     if (c != CH_SLASH) nxt[p] = 1'b1;
                    TC_DSTAR_A:  nxt[p] = 1'b1;
                    default: ;
                endcase
            end
        end
        return skip_stars(nxt);
    endfunction

    // model update for one accepted item
    task automatic glob_nfa_step(input t_in_item it);
        t_out_item verdict;
        case (it.kind)
            KIND_CLEAR: begin
                glob_len = 0;
                glob_ovf = 1'b0;
            end
            KIND_APPEND: begin
                if (glob_len >= MAXP) begin
                    glob_ovf = 1'b1;
                end else begin
                    glob_byte[glob_len] = it.byte_value;
                    if (it.byte_value == CH_STAR) begin
                        if (glob_len > 0 && glob_cls[glob_len-1] == TC_STAR) begin
                            glob_cls[glob_len-1] = TC_DSTAR_A;
                            glob_cls[glob_len]   = TC_DSTAR_B;
                        end else begin
                            glob_cls[glob_len] = TC_STAR;
                        end
                    end else if (it.byte_value == CH_QUESTION) begin
                        glob_cls[glob_len] = TC_QUESTION;
                    end else begin
                        glob_cls[glob_len] = TC_LITERAL;
                    end
                    glob_len++;
                end
            end
            KIND_SUBJECT: live_pos = advance_on(it.byte_value);
            default: begin
                verdict.matched          = live_pos[glob_len] && !glob_ovf;
                verdict.pattern_overflow = glob_ovf;
                pending_verdicts.insert(pending_verdicts.size(), verdict);
            end
        endcase
        if (it.kind != KIND_SUBJECT) live_pos = skip_stars(START_POS);
    endtask

    // send one item; valid stays high after acceptance unless a gap follows
    task automatic put(input logic [1:0] k, input logic [7:0] b);
        t_in_item it;
        int gap;
        it.kind       = k;
        it.byte_value = b;
        if (k == KIND_CLEAR) loaded_text.delete();
        else if (k == KIND_APPEND) loaded_text.insert(loaded_text.size(), b);
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        glob_nfa_step(it);
        sent_items++;
    endtask

    task automatic send_text(input logic [1:0] k, input string txt);
        for (int i = 0; i < txt.len(); i++) put(k, txt[i]);
    endtask

    // sender holds off until every verdict has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'(8'h61 + $urandom_range(0, 2));
        if (r < 50) return CH_SLASH;
        if (r < 68) return CH_STAR;
        if (r < 80) return CH_QUESTION;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_subject_byte(input logic allow_slash);
        logic [7:0] b;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            b = 8'(8'h61 + $urandom_range(0, 2));
        end else if (allow_slash && r < 85) begin
            b = CH_SLASH;
        end else begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_SLASH) b = 8'h7A;
        end
        return b;
    endfunction

    // receiver: check each result, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result with no verdict pending: matched %0b overflow %0b",
                           o_item.matched, o_item.pattern_overflow);
                    errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_item.matched !== want.matched) begin
                        $error("matched: expected %0b, got %0b", want.matched, o_item.matched);
                        errors++;
                    end
                    if (o_item.pattern_overflow !== want.pattern_overflow) begin
                        $error("pattern_overflow: expected %0b, got %0b",
                               want.pattern_overflow, o_item.pattern_overflow);
                        errors++;
                    end
                end
            end
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                i_ready <= 1'b0;
                rx_hold = idle_len();
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // corner patterns and subjects
    task automatic test_directed();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        // empty pattern against an empty and a non-empty subject
        put(KIND_END, 8'hFF);
        put(KIND_SUBJECT, "x");
        put(KIND_END, 8'h00);
        // question mark and single star, the question mark stopping at a slash
        send_text(KIND_APPEND, "a?*");
        send_text(KIND_SUBJECT, "ab");
        put(KIND_END, 8'hFF);
        send_text(KIND_SUBJECT, "a/");
        put(KIND_END, 8'h00);
        // second star pairs up into a double star, which crosses slashes
        put(KIND_APPEND, CH_STAR);
        send_text(KIND_SUBJECT, "ab/");
        put(KIND_END, 8'h00);
        // append in the middle of a subject restarts it
        put(KIND_SUBJECT, "a");
        put(KIND_APPEND, CH_SLASH);
        send_text(KIND_SUBJECT, "ax/");
        put(KIND_END, 8'h00);
        // clear in the middle of a subject
        put(KIND_SUBJECT, "q");
        put(KIND_CLEAR, 8'hFF);
        put(KIND_END, 8'h00);
        // extreme byte values as literals
        put(KIND_APPEND, 8'hFF);
        put(KIND_APPEND, 8'h00);
        put(KIND_SUBJECT, 8'hFF);
        put(KIND_SUBJECT, 8'h00);
        put(KIND_END, 8'hFF);
    endtask

    // full pattern, overflow and a double star split by it
    task automatic test_overflow();
        tx_gap_pct   = 25;
        rx_stall_pct = 25;
        put(KIND_CLEAR, 8'h00);
        repeat (MAXP - 1) put(KIND_APPEND, "a");
        put(KIND_APPEND, CH_STAR);
        put(KIND_APPEND, CH_STAR);
        repeat (MAXP - 1) put(KIND_SUBJECT, "a");
        put(KIND_END, 8'h00);
        // flag sticks until a clear
        put(KIND_END, 8'hFF);
        put(KIND_CLEAR, 8'h00);
        put(KIND_END, 8'h00);
        // exactly full, no overflow
        repeat (MAXP) put(KIND_APPEND, CH_QUESTION);
        repeat (MAXP) put(KIND_SUBJECT, "b");
        put(KIND_END, 8'h00);
    endtask

    // random patterns with subjects derived from them, plus noise
    task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
        logic [7:0] subj [$];
        int stop_at;
        int roll;
        int len;
        int cut;
        int i;
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                // new pattern, mostly short, a few past capacity
                put(KIND_CLEAR, 8'($urandom_range(0, 255)));
                roll = $urandom_range(0, 99);
                if (roll < 6) len = $urandom_range(MAXP - 4, MAXP + 6);
                else if (roll < 16) len = 0;
                else len = $urandom_range(1, 10);
                repeat (len) put(KIND_APPEND, pick_pattern_byte());
            end else if (roll < 17) begin
                put(2'($urandom_range(KIND_CLEAR, KIND_END)), 8'($urandom_range(0, 255)));
            end else begin
                // expand the loaded pattern into a subject that should match
                subj.delete();
                i = 0;
                while (i < loaded_text.size()) begin
                    if (loaded_text[i] == CH_STAR && i + 1 < loaded_text.size()
                            && loaded_text[i+1] == CH_STAR) begin
                        repeat ($urandom_range(0, 3))
                            subj.insert(subj.size(), pick_subject_byte(1'b1));
                        i += 2;
                    end else if (loaded_text[i] == CH_STAR) begin
                        repeat ($urandom_range(0, 3))
                            subj.insert(subj.size(), pick_subject_byte(1'b0));
                        i++;
                    end else if (loaded_text[i] == CH_QUESTION) begin
                        subj.insert(subj.size(), pick_subject_byte(1'b0));
                        i++;
                    end else begin
                        subj.insert(subj.size(), loaded_text[i]);
                        i++;
                    end
                end
                // near misses
                if (subj.size() > 0 && $urandom_range(0, 99) < 25) begin
                    cut = $urandom_range(0, subj.size() - 1);
                    case ($urandom_range(0, 2))
                        0: subj[cut] = pick_subject_byte(1'b1);
                        1: subj.delete(cut);
                        default: subj.insert(cut, pick_subject_byte(1'b1));
                    endcase
                end
                // broken sequence: pattern edit in the middle of the subject
                cut = -1;
                if (subj.size() > 0 && $urandom_range(0, 99) < 8)
                    cut = $urandom_range(0, subj.size() - 1);
                for (int j = 0; j < subj.size(); j++) begin
                    if (j == cut)
                        put($urandom_range(0, 1) ? KIND_APPEND : KIND_CLEAR, pick_pattern_byte());
                    put(KIND_SUBJECT, subj[j]);
                end
                put(KIND_END, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_overflow();
        test_random(300, 0, 0);
        wait_for_results();
        test_random(550, 30, 25);
        wait_for_results();
        test_random(300, 10, 60);
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("** path_glob_matcher: PASSED **");
        end else begin
            $display("** path_glob_matcher: FAILED **");
        end
        $finish;
    end

endmodule
